FILE: rtl/lcfr_pkg.sv
// Shared types, constants and the byte-wide CRC-32 function for the
// length-prefixed frame receiver. No dependencies.
`timescale 1ns / 1ps

package lcfr_pkg;

  localparam int BUFFER_BYTES = 65536;
  localparam int CNT_W        = $clog2(BUFFER_BYTES) + 1;
  localparam int HEADER_BYTES = 18;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // request kinds (tuser on the input side)
  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_LCR  = 1'b1;

  // header byte positions
  localparam logic [CNT_W-1:0] POS_LEN_LO  = CNT_W'(2);
  localparam logic [CNT_W-1:0] POS_LEN_HI  = CNT_W'(3);
  localparam logic [CNT_W-1:0] POS_INV_LO  = CNT_W'(4);
  localparam logic [CNT_W-1:0] POS_INV_HI  = CNT_W'(5);
  localparam logic [CNT_W-1:0] POS_CMD_LO  = CNT_W'(6);
  localparam logic [CNT_W-1:0] POS_CMD_HI  = CNT_W'(7);
  localparam logic [CNT_W-1:0] POS_PROC_LO = CNT_W'(12);
  localparam logic [CNT_W-1:0] POS_PROC_HI = CNT_W'(13);
  localparam logic [CNT_W-1:0] POS_CRC_B0  = CNT_W'(14);
  localparam logic [CNT_W-1:0] POS_CRC_B1  = CNT_W'(15);
  localparam logic [CNT_W-1:0] POS_CRC_B2  = CNT_W'(16);
  localparam logic [CNT_W-1:0] POS_CRC_B3  = CNT_W'(17);

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_GOOD     = 3'd1,
    ST_LEN_ERR  = 3'd2,
    ST_CRC_ERR  = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_RX_RESET = 3'd5
  } status_t;

  typedef struct packed {
    logic        done;
    status_t     status;
    logic [15:0] command;
    logic [15:0] process;
    logic [15:0] length;
  } result_t;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/lcfr_engine.sv
// Frame engine: header capture, running CRC, packet check and result register.
// Depends on lcfr_pkg.
`timescale 1ns / 1ps

module lcfr_engine (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic                    req_type,
  input  logic [7:0]              wdata,
  output lcfr_pkg::result_t       res
);

  localparam logic [lcfr_pkg::CNT_W-1:0] BUF_LIMIT = lcfr_pkg::CNT_W'(lcfr_pkg::BUFFER_BYTES);
  localparam logic [lcfr_pkg::CNT_W-1:0] HDR_LEN   = lcfr_pkg::CNT_W'(lcfr_pkg::HEADER_BYTES);

  logic                        latch_r, latch_nxt;
  logic [lcfr_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [15:0]                 len_r, len_nxt;
  logic [15:0]                 inv_r, inv_nxt;
  logic [15:0]                 cmd_r, cmd_nxt;
  logic [15:0]                 proc_r, proc_nxt;
  logic [31:0]                 rcrc_r, rcrc_nxt;
  logic [31:0]                 crc_r, crc_nxt;
  lcfr_pkg::result_t           res_r, res_nxt;

  logic [7:0]                  feed;
  logic [31:0]                 crc_upd;
  logic [lcfr_pkg::CNT_W-1:0]  count_inc;

  assign crc_upd   = lcfr_pkg::crc_byte(crc_r, feed);
  assign count_inc = count_r + lcfr_pkg::CNT_W'(1);

  always_comb begin
    latch_nxt = latch_r;
    count_nxt = count_r;
    len_nxt   = len_r;
    inv_nxt   = inv_r;
    cmd_nxt   = cmd_r;
    proc_nxt  = proc_r;
    rcrc_nxt  = rcrc_r;
    crc_nxt   = crc_r;
    feed      = wdata;
    res_nxt   = '0;
    case (count_r)
      lcfr_pkg::POS_CRC_B0, lcfr_pkg::POS_CRC_B1,
      lcfr_pkg::POS_CRC_B2, lcfr_pkg::POS_CRC_B3: feed = 8'd0;
      default: feed = wdata;
    endcase
    if (req_type == lcfr_pkg::REQ_LCR) begin
      if (wdata[7] != latch_r) begin
        latch_nxt      = wdata[7];
        count_nxt      = '0;
        crc_nxt        = lcfr_pkg::CRC_INIT;
        res_nxt.done   = 1'b1;
        res_nxt.status = lcfr_pkg::ST_RX_RESET;
      end
    end else if (!latch_r) begin
      if (count_r >= BUF_LIMIT) begin
        count_nxt      = '0;
        crc_nxt        = lcfr_pkg::CRC_INIT;
        res_nxt.done   = 1'b1;
        res_nxt.status = lcfr_pkg::ST_OVERFLOW;
      end else begin
        case (count_r)
          lcfr_pkg::POS_LEN_LO:  len_nxt[7:0]    = wdata;
          lcfr_pkg::POS_LEN_HI:  len_nxt[15:8]   = wdata;
          lcfr_pkg::POS_INV_LO:  inv_nxt[7:0]    = wdata;
          lcfr_pkg::POS_INV_HI:  inv_nxt[15:8]   = wdata;
          lcfr_pkg::POS_CMD_LO:  cmd_nxt[7:0]    = wdata;
          lcfr_pkg::POS_CMD_HI:  cmd_nxt[15:8]   = wdata;
          lcfr_pkg::POS_PROC_LO: proc_nxt[7:0]   = wdata;
          lcfr_pkg::POS_PROC_HI: proc_nxt[15:8]  = wdata;
          lcfr_pkg::POS_CRC_B0:  rcrc_nxt[7:0]   = wdata;
          lcfr_pkg::POS_CRC_B1:  rcrc_nxt[15:8]  = wdata;
          lcfr_pkg::POS_CRC_B2:  rcrc_nxt[23:16] = wdata;
          lcfr_pkg::POS_CRC_B3:  rcrc_nxt[31:24] = wdata;
          default: ;
        endcase
        if (count_inc >= HDR_LEN && {1'b0, len_nxt} == count_inc) begin
          count_nxt       = '0;
          crc_nxt         = lcfr_pkg::CRC_INIT;
          res_nxt.done    = 1'b1;
          res_nxt.command = cmd_nxt;
          res_nxt.process = proc_nxt;
          res_nxt.length  = len_nxt;
          if (len_nxt != ~inv_nxt)
            res_nxt.status = lcfr_pkg::ST_LEN_ERR;
          else if (~crc_upd != rcrc_nxt)
            res_nxt.status = lcfr_pkg::ST_CRC_ERR;
          else
            res_nxt.status = lcfr_pkg::ST_GOOD;
        end else begin
          count_nxt = count_inc;
          crc_nxt   = crc_upd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r <= 1'b0;
      count_r <= '0;
      len_r   <= '0;
      inv_r   <= '0;
      cmd_r   <= '0;
      proc_r  <= '0;
      rcrc_r  <= '0;
      crc_r   <= lcfr_pkg::CRC_INIT;
      res_r   <= '0;
    end else if (step) begin
      latch_r <= latch_nxt;
      count_r <= count_nxt;
      len_r   <= len_nxt;
      inv_r   <= inv_nxt;
      cmd_r   <= cmd_nxt;
      proc_r  <= proc_nxt;
      rcrc_r  <= rcrc_nxt;
      crc_r   <= crc_nxt;
      res_r   <= res_nxt;
    end
  end

  assign res = res_r;

  a_done_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
    res_r.done == (res_r.status != lcfr_pkg::ST_NONE))
    else $error("done flag disagrees with status");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= BUF_LIMIT)
    else $error("byte count beyond buffer size");

  a_latch_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    step && req_type == lcfr_pkg::REQ_DATA && latch_r |=> $stable(count_r) && $stable(crc_r))
    else $error("data byte taken while divisor latch set");

  a_fields_only_on_check: assert property (@(posedge clk) disable iff (!rst_n)
    (res_r.status == lcfr_pkg::ST_NONE || res_r.status == lcfr_pkg::ST_OVERFLOW ||
     res_r.status == lcfr_pkg::ST_RX_RESET)
    |-> res_r.command == 16'd0 && res_r.process == 16'd0 && res_r.length == 16'd0)
    else $error("packet fields reported without a checked packet");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    $past(step) && res_r.done && $past(rst_n) |-> count_r == '0 && crc_r == lcfr_pkg::CRC_INIT)
    else $error("count or crc not restarted after a reported event");

endmodule

FILE: rtl/length_crc_frame_receiver_core.sv
// Top level of the length-prefixed CRC-32 frame receiver.
// Depends on lcfr_pkg and lcfr_engine.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_*): one beat per register write. in_tuser selects the
//   register (0 data byte, 1 line control), in_tdata carries the byte.
//   Output channel (out_*): exactly one beat per input beat, in order.
//   out_tlast marks a beat that completed or aborted a packet, out_tuser is
//   the status code, out_tdata holds command, process id and length.
//   An accepted beat is held in the input register, and its result is registered
//   in the engine's result register before it is presented at the output.
//   Throughput: one beat per cycle unless out_tready stalls; header capture,
//   byte-wide CRC update and packet check finish in one register-to-register pass.
//   Reset (rst_n low, synchronous) clears the divisor latch, the byte count,
//   the header words and restarts the CRC; both channels empty.
//   When out_tready is low the result stays in the output register, one more
//   beat is held in the input register, and in_tready then drops.
//
module length_crc_frame_receiver_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] wdata
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] frame_command, [31:16] frame_process,
                                  // [47:32] frame_length
  output logic        out_tlast,  // frame_done
  output logic [2:0]  out_tuser   // [2:0] frame_status
);

  logic              in_valid_r, in_valid_nxt;
  logic              in_type_r;
  logic [7:0]        in_byte_r;
  logic              out_valid_r, out_valid_nxt;
  logic              step;
  logic              in_fire;
  lcfr_pkg::result_t res;

  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;
  assign in_fire   = in_tvalid && in_tready;

  assign in_valid_nxt  = in_fire || (in_valid_r && !step);
  assign out_valid_nxt = step || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_type_r <= in_tuser;
      in_byte_r <= in_tdata;
    end
  end

  lcfr_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .req_type (in_type_r),
    .wdata    (in_byte_r),
    .res      (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res.length, res.process, res.command};
  assign out_tlast  = res.done;
  assign out_tuser  = res.status;

endmodule

FILE: dv/length_crc_frame_receiver_core_tb.sv
// Self-checking testbench for length_crc_frame_receiver_core: register-write beats
// in, one status beat out per write, checked against a frame predictor in the bench.
// Depends on lcfr_pkg and the receiver RTL.
`timescale 1ns / 1ps

module length_crc_frame_receiver_core_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BEATS = 300;

  typedef struct {
    logic              kind;
    logic [7:0]        wbyte;
    bit                fixed;
    logic              done;
    lcfr_pkg::status_t status;
    logic [15:0]       cmd;
    logic [15:0]       proc;
    logic [15:0]       len;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic [2:0]  out_tuser;

  // predictor state
  logic                       rx_latched;
  logic [lcfr_pkg::CNT_W-1:0] rx_count;
  logic [15:0]                hdr_len, hdr_inv, hdr_cmd, hdr_proc;
  logic [31:0]                hdr_crc, crc_acc;

  lcfr_pkg::result_t frame_results_q[$];
  lcfr_pkg::result_t head;
  logic [7:0]        frame_bytes[$];
  dir_row_t          dir_tab[24];
  int                fails = 0;
  int                busy_beats;
  int                in_idle, out_idle;
  int                stall_cycles = 0;

  always #10 clk = ~clk;

  length_crc_frame_receiver_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  function automatic logic [31:0] crc_feed(input logic [31:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[i];
      c  = c >> 1;
      if (fb) c = c ^ lcfr_pkg::CRC_POLY;
    end
    return c;
  endfunction

  function automatic void rx_clear();
    hdr_len  = '0;
    hdr_inv  = '0;
    hdr_cmd  = '0;
    hdr_proc = '0;
    hdr_crc  = '0;
    rx_latched = 1'b0;
    rx_count = '0;
    crc_acc  = lcfr_pkg::CRC_INIT;
  endfunction

  function automatic lcfr_pkg::result_t rx_predict(input logic kind, input logic [7:0] b);
    lcfr_pkg::result_t r;
    logic [7:0]        feed;
    r = '0;
    r.status = lcfr_pkg::ST_NONE;
    if (kind == lcfr_pkg::REQ_LCR) begin
      if (b[7] != rx_latched) begin
        rx_latched = b[7];
        rx_count = '0;
        crc_acc  = lcfr_pkg::CRC_INIT;
        r.done   = 1'b1;
        r.status = lcfr_pkg::ST_RX_RESET;
      end
    end else if (!rx_latched) begin
      if (rx_count >= lcfr_pkg::BUFFER_BYTES) begin
        rx_count = '0;
        crc_acc  = lcfr_pkg::CRC_INIT;
        r.done   = 1'b1;
        r.status = lcfr_pkg::ST_OVERFLOW;
      end else begin
        feed = b;
        case (rx_count)
          lcfr_pkg::POS_LEN_LO:  hdr_len[7:0]   = b;
          lcfr_pkg::POS_LEN_HI:  hdr_len[15:8]  = b;
          lcfr_pkg::POS_INV_LO:  hdr_inv[7:0]   = b;
          lcfr_pkg::POS_INV_HI:  hdr_inv[15:8]  = b;
          lcfr_pkg::POS_CMD_LO:  hdr_cmd[7:0]   = b;
          lcfr_pkg::POS_CMD_HI:  hdr_cmd[15:8]  = b;
          lcfr_pkg::POS_PROC_LO: hdr_proc[7:0]  = b;
          lcfr_pkg::POS_PROC_HI: hdr_proc[15:8] = b;
          lcfr_pkg::POS_CRC_B0, lcfr_pkg::POS_CRC_B1,
          lcfr_pkg::POS_CRC_B2, lcfr_pkg::POS_CRC_B3: begin
            hdr_crc[8*(rx_count - lcfr_pkg::POS_CRC_B0) +: 8] = b;
            feed = 8'h00;
          end
          default: ;
        endcase
        crc_acc  = crc_feed(crc_acc, feed);
        rx_count = rx_count + lcfr_pkg::CNT_W'(1);
        if (rx_count >= lcfr_pkg::HEADER_BYTES && {1'b0, hdr_len} == rx_count) begin
          r.done    = 1'b1;
          r.command = hdr_cmd;
          r.process = hdr_proc;
          r.length  = hdr_len;
          if (hdr_len != ~hdr_inv)          r.status = lcfr_pkg::ST_LEN_ERR;
          else if (~crc_acc != hdr_crc)     r.status = lcfr_pkg::ST_CRC_ERR;
          else                              r.status = lcfr_pkg::ST_GOOD;
          rx_count = '0;
          crc_acc  = lcfr_pkg::CRC_INIT;
        end
      end
    end
    return r;
  endfunction

  // call at a rising edge; returns at the edge where the beat is taken
  task automatic push_beat(input logic kind, input logic [7:0] b, input bit fixed,
                           input lcfr_pkg::result_t want);
    lcfr_pkg::result_t calc;
    bit                ignored;
    if ($urandom_range(99) < in_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    ignored = (kind == lcfr_pkg::REQ_DATA) ? rx_latched : (b[7] == rx_latched);
    calc = rx_predict(kind, b);
    frame_results_q.push_back(fixed ? want : calc);
    if (!ignored) busy_beats++;
  endtask

  // mode 0 good, 1 bad length complement, 2 bad crc
  task automatic make_frame(input int len_field, input int mode);
    logic [15:0] lw, iw;
    logic [31:0] c, flip;
    int          n;
    frame_bytes.delete();
    lw = len_field[15:0];
    iw = ~lw;
    if (mode == 1) iw = iw ^ 16'($urandom_range(1, 65535));
    n = (len_field < lcfr_pkg::HEADER_BYTES) ? lcfr_pkg::HEADER_BYTES : len_field;
    for (int i = 0; i < n; i++) frame_bytes.push_back(8'($urandom_range(255)));
    frame_bytes[lcfr_pkg::POS_LEN_LO] = lw[7:0];
    frame_bytes[lcfr_pkg::POS_LEN_HI] = lw[15:8];
    frame_bytes[lcfr_pkg::POS_INV_LO] = iw[7:0];
    frame_bytes[lcfr_pkg::POS_INV_HI] = iw[15:8];
    c = lcfr_pkg::CRC_INIT;
    for (int i = 0; i < n; i++)
      c = crc_feed(c, (i >= lcfr_pkg::POS_CRC_B0 && i <= lcfr_pkg::POS_CRC_B3) ?
                      8'h00 : frame_bytes[i]);
    c = ~c;
    if (mode == 2) begin
      do flip = $urandom(); while (flip == 0);
      c = c ^ flip;
    end
    for (int i = 0; i < 4; i++) frame_bytes[lcfr_pkg::POS_CRC_B0 + i] = c[8*i +: 8];
  endtask

  // toggling the divisor latch on and off always restarts the receiver
  task automatic restart_rx();
    push_beat(lcfr_pkg::REQ_LCR, {1'b1, 7'($urandom_range(127))}, 1'b0, '0);
    push_beat(lcfr_pkg::REQ_LCR, {1'b0, 7'($urandom_range(127))}, 1'b0, '0);
  endtask

  task automatic rand_sequence();
    int sel, len, mode, cut, n;
    sel  = $urandom_range(99);
    len  = ($urandom_range(9) == 0) ? $urandom_range(49, 600) : $urandom_range(18, 48);
    mode = $urandom_range(99);
    mode = (mode < 76) ? 0 : (mode < 88) ? 1 : 2;
    if (sel < 78) begin
      make_frame(len, mode);
      foreach (frame_bytes[i]) push_beat(lcfr_pkg::REQ_DATA, frame_bytes[i], 1'b0, '0);
    end else if (sel < 89) begin
      make_frame(len, mode);
      cut = $urandom_range(1, len - 1);
      for (int i = 0; i < cut; i++)
        push_beat(lcfr_pkg::REQ_DATA, frame_bytes[i], 1'b0, '0);
      restart_rx();
    end else begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        push_beat($urandom_range(1) ? lcfr_pkg::REQ_LCR : lcfr_pkg::REQ_DATA,
                  8'($urandom_range(255)), 1'b0, '0);
      restart_rx();
    end
  endtask

  // result side: check, then pick next tready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_results_q.size() == 0) begin
        $error("result beat with nothing expected: tlast %0b tuser %0d tdata %h",
               out_tlast, out_tuser, out_tdata);
        fails++;
      end else begin
        head = frame_results_q.pop_front();
        if (out_tlast !== head.done) begin
          $error("frame_done: expected %0b, got %0b", head.done, out_tlast);
          fails++;
        end
        if (out_tuser !== head.status) begin
          $error("frame_status: expected %0d, got %0d", head.status, out_tuser);
          fails++;
        end
        if (out_tdata[15:0] !== head.command) begin
          $error("frame_command: expected %h, got %h", head.command, out_tdata[15:0]);
          fails++;
        end
        if (out_tdata[31:16] !== head.process) begin
          $error("frame_process: expected %h, got %h", head.process, out_tdata[31:16]);
          fails++;
        end
        if (out_tdata[47:32] !== head.length) begin
          $error("frame_length: expected %h, got %h", head.length, out_tdata[47:32]);
          fails++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= out_idle);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = lcfr_pkg::REQ_DATA;
    out_tready = 1'b0;
    in_idle    = 31;
    out_idle   = 74;
    rx_clear();

    dir_tab = '{
      '{lcfr_pkg::REQ_DATA, 8'h00, 1'b1, 1'b0, lcfr_pkg::ST_NONE,     16'h0, 16'h0, 16'h0},
      '{lcfr_pkg::REQ_LCR,  8'h80, 1'b1, 1'b1, lcfr_pkg::ST_RX_RESET, 16'h0, 16'h0, 16'h0},
      '{lcfr_pkg::REQ_DATA, 8'hFF, 1'b1, 1'b0, lcfr_pkg::ST_NONE,     16'h0, 16'h0, 16'h0},
      '{lcfr_pkg::REQ_LCR,  8'hFF, 1'b1, 1'b0, lcfr_pkg::ST_NONE,     16'h0, 16'h0, 16'h0},
      '{lcfr_pkg::REQ_LCR,  8'h00, 1'b1, 1'b1, lcfr_pkg::ST_RX_RESET, 16'h0, 16'h0, 16'h0},
      '{lcfr_pkg::REQ_LCR,  8'h7F, 1'b1, 1'b0, lcfr_pkg::ST_NONE,     16'h0, 16'h0, 16'h0},
      // 18-byte frame, length complement left at zero
      '{lcfr_pkg::REQ_DATA, 8'hA5, 1'b0, 1'b0, lcfr_pkg::ST_NONE,     16'h0, 16'h0, 16'h0},
      '{lcfr_pkg::REQ_DATA, 8'h5A, 1'b0, 1'b0, lcfr_pkg::ST_NONE,     16'h0, 16'h0, 16'h0},
      '{lcfr_pkg::REQ_DATA, 8'h12, 1'b0, 1'b0, lcfr_pkg::ST_NONE,     16'h0, 16'h0, 16'h0},
      '{lcfr_pkg::REQ_DATA, 8'h00, 1'b0, 1'b0, lcfr_pkg::ST_NONE,     16'h0, 16'h0, 16'h0},
      '{lcfr_pkg::REQ_DATA, 8'h00, 1'b0, 1'b0, lcfr_pkg::ST_NONE,     16'h0, 16'h0, 16'h0},
      '{lcfr_pkg::REQ_DATA, 8'h00, 1'b0, 1'b0, lcfr_pkg::ST_NONE,     16'h0, 16'h0, 16'h0},
      '{lcfr_pkg::REQ_DATA, 8'h34, 1'b0, 1'b0, lcfr_pkg::ST_NONE,     16'h0, 16'h0, 16'h0},
      '{lcfr_pkg::REQ_DATA, 8'h12, 1'b0, 1'b0, lcfr_pkg::ST_NONE,     16'h0, 16'h0, 16'h0},
      '{lcfr_pkg::REQ_DATA, 8'hFF, 1'b0, 1'b0, lcfr_pkg::ST_NONE,     16'h0, 16'h0, 16'h0},
      '{lcfr_pkg::REQ_DATA, 8'hFF, 1'b0, 1'b0, lcfr_pkg::ST_NONE,     16'h0, 16'h0, 16'h0},
      '{lcfr_pkg::REQ_DATA, 8'hFF, 1'b0, 1'b0, lcfr_pkg::ST_NONE,     16'h0, 16'h0, 16'h0},
      '{lcfr_pkg::REQ_DATA, 8'hFF, 1'b0, 1'b0, lcfr_pkg::ST_NONE,     16'h0, 16'h0, 16'h0},
      '{lcfr_pkg::REQ_DATA, 8'h78, 1'b0, 1'b0, lcfr_pkg::ST_NONE,     16'h0, 16'h0, 16'h0},
      '{lcfr_pkg::REQ_DATA, 8'h56, 1'b0, 1'b0, lcfr_pkg::ST_NONE,     16'h0, 16'h0, 16'h0},
      '{lcfr_pkg::REQ_DATA, 8'h00, 1'b0, 1'b0, lcfr_pkg::ST_NONE,     16'h0, 16'h0, 16'h0},
      '{lcfr_pkg::REQ_DATA, 8'h00, 1'b0, 1'b0, lcfr_pkg::ST_NONE,     16'h0, 16'h0, 16'h0},
      '{lcfr_pkg::REQ_DATA, 8'h00, 1'b0, 1'b0, lcfr_pkg::ST_NONE,     16'h0, 16'h0, 16'h0},
      '{lcfr_pkg::REQ_DATA, 8'h00, 1'b1, 1'b1, lcfr_pkg::ST_LEN_ERR,
        16'h1234, 16'h5678, 16'h0012}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      push_beat(dir_tab[i].kind, dir_tab[i].wbyte, dir_tab[i].fixed,
                {dir_tab[i].done, dir_tab[i].status, dir_tab[i].cmd,
                 dir_tab[i].proc, dir_tab[i].len});

    for (int ph = 0; ph < 3; ph++) begin
      in_idle  = (ph == 0) ? 31 : (ph == 1) ? 74 : 0;
      out_idle = (ph == 0) ? 74 : (ph == 1) ? 31 : 0;
      busy_beats = 0;
      while (busy_beats < PHASE_BEATS) rand_sequence();
    end

    // short length word: the packet never completes, the receiver is then restarted
    restart_rx();
    make_frame($urandom_range(0, lcfr_pkg::HEADER_BYTES - 1), 0);
    foreach (frame_bytes[i]) push_beat(lcfr_pkg::REQ_DATA, frame_bytes[i], 1'b0, '0);
    restart_rx();
    for (int i = 0; i < 4; i++) rand_sequence();

    in_tvalid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/lcfr_pkg.sv
rtl/lcfr_engine.sv
rtl/length_crc_frame_receiver_core.sv
dv/length_crc_frame_receiver_core_tb.sv
